>>> rtl/core/hsfc_pkg.sv
// types and constants for the half/single float converter
// no dependencies; imported by half_single_float_converter and tb_top
package hsfc_pkg;

    // result class decided at decode
    typedef enum logic [2:0] {
        CLS_ZERO   = 3'd0,
        CLS_INF    = 3'd1,
        CLS_NAN    = 3'd2,
        CLS_HALF   = 3'd3,
        CLS_SINGLE = 3'd4
    } t_cls;

    // direction codes carried in tuser
    localparam logic DIR_S2H = 1'b0;
    localparam logic DIR_H2S = 1'b1;

    // format constants
    localparam logic [7:0]  SGL_EXP_MAX   = 8'hFF;
    localparam logic [7:0]  SGL_EXP_OVF   = 8'd143;
    localparam logic [7:0]  SGL_EXP_UNF   = 8'd112;
    localparam logic [7:0]  SGL_DEN_BASE  = 8'd126;
    localparam logic [7:0]  SGL_SH_MAX    = 8'd24;
    localparam logic [4:0]  HALF_EXP_MAX  = 5'h1F;
    localparam logic [7:0]  REBIAS        = 8'd112;
    localparam logic [7:0]  H2S_DEN_BASE  = 8'd113;
    localparam logic [15:0] HALF_NAN      = 16'hFE00;

    // decode stage payload
    typedef struct packed {
        logic        dir;
        t_cls        cls;
        logic        sign;
        logic        den;
        logic [4:0]  sh;
        logic [4:0]  ex5;
        logic [23:0] mant;
    } t_stage1;

    // shift stage payload
    typedef struct packed {
        logic        dir;
        t_cls        cls;
        logic        sign;
        logic [7:0]  ex8;
        logic [9:0]  frac;
        logic        rnd;
    } t_stage2;

endpackage

>>> rtl/core/half_single_float_converter.sv
// half/single float converter, three-stage pipeline with stream ports
// depends on hsfc_pkg
//
// Converts IEEE binary32 to binary16 (tuser 0) or binary16 to binary32 (tuser 1),
// one item per clock cycle while the output does not stall. An accepted input passes
// the decode, shift and round/assemble registers in order before its result is valid;
// each owns one register stage. Single to half rounds on the first dropped bit only,
// any single NaN gives 0xFE00, and half infinities and NaNs convert to +0.0. A stall on the
// output holds the pipeline in place; the input keeps accepting items while empty
// stages remain.
module half_single_float_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] operand
    input  logic        s_axis_tuser,  // [0] direction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] result_word
);
    import hsfc_pkg::*;

    logic        r_v1, r_v2, r_v3;
    t_stage1     r_s1, n_s1;
    t_stage2     r_s2, n_s2;
    logic [31:0] r_tdata, n_tdata;
    logic        r_dir3;
    logic        w_rdy1, w_rdy2, w_rdy3;

    // ready chain, a stage advances when empty or when the next one advances
    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_tdata;

    // stage 1: classify and prepare shift amount
    always_comb begin
        logic [7:0] exp;
        logic [22:0] man;
        logic [7:0] sh8;
        logic [4:0] hexp;
        logic [9:0] hman;
        logic [3:0] p;
        exp  = s_axis_tdata[30:23];
        man  = s_axis_tdata[22:0];
        hexp = s_axis_tdata[14:10];
        hman = s_axis_tdata[9:0];
        sh8  = SGL_DEN_BASE - exp;
        p    = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (hman[i]) begin
                p = 4'(i);
            end
        end
        n_s1      = '0;
        n_s1.dir  = s_axis_tuser;
        n_s1.cls  = CLS_ZERO;
        if (s_axis_tuser == DIR_S2H) begin
            n_s1.sign = s_axis_tdata[31];
            n_s1.mant = {1'b1, man};
            if (exp == 8'd0) begin
                n_s1.cls = CLS_ZERO;
            end else if (exp == SGL_EXP_MAX) begin
                n_s1.cls = (man == 23'd0) ? CLS_INF : CLS_NAN;
            end else if (exp >= SGL_EXP_OVF) begin
                n_s1.cls = CLS_INF;
            end else if (exp <= SGL_EXP_UNF) begin
                if (sh8 > SGL_SH_MAX) begin
                    n_s1.cls = CLS_ZERO;
                end else begin
                    n_s1.cls = CLS_HALF;
                    n_s1.den = 1'b1;
                    n_s1.sh  = sh8[4:0];
                end
            end else begin
                n_s1.cls = CLS_HALF;
                n_s1.ex5 = 5'(exp - REBIAS);
            end
        end else begin
            n_s1.sign = s_axis_tdata[15];
            n_s1.mant = {14'd0, hman};
            n_s1.ex5  = hexp;
            if (s_axis_tdata[14:0] == 15'd0) begin
                n_s1.cls = CLS_ZERO;
            end else if (hexp == HALF_EXP_MAX) begin
                n_s1.cls  = CLS_ZERO;
                n_s1.sign = 1'b0;
            end else if (hexp == 5'd0) begin
                n_s1.cls = CLS_SINGLE;
                n_s1.den = 1'b1;
                n_s1.sh  = 5'd10 - {1'b0, p};
            end else begin
                n_s1.cls = CLS_SINGLE;
            end
        end
    end

    // stage 2: alignment shifts and exponent rebias
    always_comb begin
        logic [24:0] rsh;
        logic [10:0] lsh;
        rsh       = {r_s1.mant, 1'b0} >> r_s1.sh;
        lsh       = {1'b0, r_s1.mant[9:0]} << r_s1.sh;
        n_s2.dir  = r_s1.dir;
        n_s2.cls  = r_s1.cls;
        n_s2.sign = r_s1.sign;
        n_s2.ex8  = {3'd0, r_s1.ex5};
        n_s2.frac = r_s1.mant[22:13];
        n_s2.rnd  = r_s1.mant[12];
        if (r_s1.dir == DIR_S2H) begin
            if (r_s1.den) begin
                n_s2.ex8  = 8'd0;
                n_s2.frac = rsh[10:1];
                n_s2.rnd  = rsh[0];
            end
        end else begin
            n_s2.rnd = 1'b0;
            if (r_s1.den) begin
                n_s2.ex8  = H2S_DEN_BASE - {3'd0, r_s1.sh};
                n_s2.frac = lsh[9:0];
            end else begin
                n_s2.ex8  = {3'd0, r_s1.ex5} + REBIAS;
                n_s2.frac = r_s1.mant[9:0];
            end
        end
    end

    // stage 3: rounding carry and result assembly
    always_comb begin
        logic [15:0] half;
        half = {r_s2.sign, r_s2.ex8[4:0], r_s2.frac} + {15'd0, r_s2.rnd};
        case (r_s2.cls)
            CLS_ZERO:   n_tdata = (r_s2.dir == DIR_H2S) ? {r_s2.sign, 31'd0}
                                                        : {16'd0, r_s2.sign, 15'd0};
            CLS_INF:    n_tdata = {16'd0, r_s2.sign, HALF_EXP_MAX, 10'd0};
            CLS_NAN:    n_tdata = {16'd0, HALF_NAN};
            CLS_HALF:   n_tdata = {16'd0, half};
            CLS_SINGLE: n_tdata = {r_s2.sign, r_s2.ex8, r_s2.frac, 13'd0};
            default:    n_tdata = 32'd0;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (w_rdy3 && r_v2) begin
            r_tdata <= n_tdata;
            r_dir3  <= r_s2.dir;
        end
    end

`ifndef SYNTHESIS
    // half results never set the upper half of the word
    a_half_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_dir3 == DIR_S2H) |-> (r_tdata[31:16] == 16'd0))
        else $error("half result with upper bits set");

    // single results never carry an all-ones exponent
    a_single_no_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_dir3 == DIR_H2S) |-> (r_tdata[30:23] != SGL_EXP_MAX))
        else $error("single result with special exponent");

    // middle stage holds while the output is blocked
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !m_axis_tready) |=> (r_v2 && $stable(r_s2)))
        else $error("stage 2 changed under stall");

    // input backpressure only when every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked with an empty stage");
`endif

endmodule

>>> bench/tb_top.sv
// testbench for half_single_float_converter: directed and random conversions
// both ways, checked item by item against a bit-exact predictor kept in a scoreboard
// depends on hsfc_pkg and half_single_float_converter
module tb_top;
    import hsfc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] operand
    logic        s_axis_tuser;   // [0] direction
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] result_word

    // idle rates in percent, and the long output hold-off
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_hold = 1'b0;

    // expected conversions, oldest first
    class conversion_scoreboard;
        typedef struct {
            logic        dir;
            logic [31:0] operand;
            logic [31:0] want;
        } t_conv;

        t_conv conv_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // binary32 to binary16, rounding on the first dropped bit only
        static function logic [15:0] to_half(logic [31:0] x);
            logic        sgn;
            logic [7:0]  ex;
            logic [22:0] man;
            logic [23:0] full;
            logic [15:0] mag;
            logic [15:0] h;
            int unsigned shamt;
            sgn = x[31];
            ex  = x[30:23];
            man = x[22:0];
            // zeros and single denormals flush to a signed zero
            if (ex == 8'h00)
                return {sgn, 15'd0};
            if (ex == 8'hFF)
                return (man == 23'd0) ? {sgn, 15'h7C00} : 16'hFE00;
            if (ex >= 8'd143)
                return {sgn, 15'h7C00};
            // underflow into a half denormal
            if (ex <= 8'd112) begin
                shamt = 126 - ex;
                if (shamt > 24)
                    return {sgn, 15'd0};
                full = {1'b1, man};
                mag  = 16'(full >> shamt);
                if (full[shamt-1])
                    mag = mag + 16'd1;
                return {sgn, 15'd0} | mag;
            end
            // normal range, carry may ripple into the exponent
            h = {sgn, 5'(ex - 8'd112), man[22:13]};
            if (man[12])
                h = h + 16'd1;
            return h;
        endfunction

        // binary16 to binary32, exact except inf and nan go to +0.0
        static function logic [31:0] to_single(logic [15:0] h);
            logic        sgn;
            logic [4:0]  ex;
            logic [10:0] m;
            int          lz;
            sgn = h[15];
            ex  = h[14:10];
            m   = {1'b0, h[9:0]};
            if (h[14:0] == 15'd0)
                return {sgn, 31'd0};
            if (ex == 5'h1F)
                return 32'd0;
            // denormal: normalize until the hidden bit shows
            if (ex == 5'd0) begin
                lz = 0;
                while (!m[10]) begin
                    m  = m << 1;
                    lz = lz + 1;
                end
                return {sgn, 8'(113 - lz), m[9:0], 13'd0};
            end
            return {sgn, 8'({3'd0, ex} + 8'd112), m[9:0], 13'd0};
        endfunction

        function void note_item(logic dir, logic [31:0] operand);
            t_conv c;
            c.dir     = dir;
            c.operand = operand;
            if (dir == hsfc_pkg::DIR_H2S)
                c.want = to_single(operand[15:0]);
            else
                c.want = {16'd0, to_half(operand)};
            conv_q.push_back(c);
        endfunction

        function void check_result(logic [31:0] got);
            t_conv c;
            if (conv_q.size() == 0) begin
                report($sformatf("result %08h arrived with nothing pending", got));
                return;
            end
            c = conv_q.pop_front();
            if (got !== c.want)
                report($sformatf("dir %0d operand %08h: expected %08h, got %08h",
                                 c.dir, c.operand, c.want, got));
        endfunction

        function void check_drained();
            if (conv_q.size() != 0)
                report($sformatf("%0d results never arrived", conv_q.size()));
        endfunction

        function int outstanding();
            return conv_q.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction
    endclass

    conversion_scoreboard conv_sb = new();

    half_single_float_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // output ready, random stalls plus the long hold-off
    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            conv_sb.check_result(m_axis_tdata);
    end

    // offer one item, entered and left at a falling edge
    task automatic send_item(input logic dir, input logic [31:0] operand);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        s_axis_tuser  <= dir;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        conv_sb.note_item(dir, operand);
        @(negedge i_clk);
    endtask

    // hold the output off long enough to back the pipeline up
    task automatic hold_output(input int cycles);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    // random item, weighted toward exponent ranges with special handling
    task automatic send_random();
        logic [31:0] w;
        int          sel;
        w   = $urandom();
        sel = $urandom_range(15);
        if (sel < 9) begin
            if (sel >= 1 && sel <= 4) begin
                // around overflow, normal and underflow boundaries
                w[30:23] = 8'($urandom_range(100, 145));
            end else if (sel == 5) begin
                w[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(1))
                    w[22:0] = 23'd0;
            end else if (sel >= 6) begin
                // mantissa that carries on rounding
                w[30:23] = 8'($urandom_range(100, 143));
                w[22:12] = '1;
            end
            send_item(DIR_S2H, w);
        end else begin
            if (sel == 9 || sel == 10)
                w[14:10] = 5'd0;
            else if (sel == 11)
                w[14:10] = 5'h1F;
            else if (sel == 12)
                w[14:0] = 15'd0;
            send_item(DIR_H2S, w);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tuser  = DIR_S2H;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: single to half
        send_item(DIR_S2H, 32'h0000_0000);  // positive zero
        send_item(DIR_S2H, 32'h8000_0000);  // negative zero
        send_item(DIR_S2H, 32'h0000_0001);  // smallest denormal
        send_item(DIR_S2H, 32'h807F_FFFF);  // largest negative denormal
        send_item(DIR_S2H, 32'h7F80_0000);  // positive infinity
        send_item(DIR_S2H, 32'hFF80_0000);  // negative infinity
        send_item(DIR_S2H, 32'h7FC0_0000);  // quiet nan
        send_item(DIR_S2H, 32'hFFFF_FFFF);  // negative nan, full payload
        send_item(DIR_S2H, 32'h4780_0000);  // first overflowing exponent
        send_item(DIR_S2H, 32'hFF7F_FFFF);  // largest finite single, negative
        send_item(DIR_S2H, 32'h477F_E000);  // largest finite half
        send_item(DIR_S2H, 32'h477F_F000);  // rounds up to infinity
        send_item(DIR_S2H, 32'h387F_F000);  // denormal rounds to smallest normal
        send_item(DIR_S2H, 32'h3800_0000);  // top of underflow range
        send_item(DIR_S2H, 32'hB300_0000);  // widest shift that still rounds
        send_item(DIR_S2H, 32'h3280_0000);  // shift too wide, magnitude lost
        send_item(DIR_S2H, 32'h3F80_1000);  // round half up in normal range
        // directed: half to single
        send_item(DIR_H2S, 32'h0000_0000);  // positive zero
        send_item(DIR_H2S, 32'hFFFF_8000);  // negative zero, high bits ignored
        send_item(DIR_H2S, 32'h0000_0001);  // smallest denormal
        send_item(DIR_H2S, 32'h0000_83FF);  // largest negative denormal
        send_item(DIR_H2S, 32'h0000_FC00);  // infinity goes to zero
        send_item(DIR_H2S, 32'h0000_7E00);  // nan goes to zero
        send_item(DIR_H2S, 32'h0000_7BFF);  // largest finite half
        send_item(DIR_H2S, 32'h5A5A_3C00);  // one, with noise above

        // random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 6 : 0;
            rx_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 6 : 0;
            for (int n = 0; n < 465; n++) begin
                if (ph == 0 && n == 100)
                    fork
                        hold_output(60);
                    join_none
                send_random();
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow the pipeline latency to settle
        rx_stall_pct = 0;
        while (conv_sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        conv_sb.check_drained();
        if (conv_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #800000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
